### hw/rtl/uart_pkg.sv
`timescale 1ns / 1ps

package uart_pkg;

    localparam int DATA_BITS   = 8;
    localparam int TIMER_WIDTH = 16;

    // Widths of the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Request kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RX_BIT_TIME      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_HALF_BIT_TIME = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_BIT_TIME      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_STOP_TIME     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_START_DELAY   = 3'd4;

    // Register reset values
    localparam int RST_RX_BIT_TIME      = 1666;
    localparam int RST_RX_HALF_BIT_TIME = 833;
    localparam int RST_TX_BIT_TIME      = 1650;
    localparam int RST_TX_STOP_TIME     = 1333;
    localparam int RST_TX_START_DELAY   = 14;

    typedef struct packed {
        logic [1:0] kind;
        logic       rx_level;
        logic [7:0] tx_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_level;
        logic       tx_busy;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_done;
        logic       overrun;
    } out_item_t;

endpackage

### hw/rtl/timer_based_uart_8n1.sv
// Full-duplex 8N1 UART advanced by tick requests.
// Input channel (in_valid/in_ready/in_data): each request is a timer tick
// (samples rx_level, advances both timers), a send request (starts a frame
// with tx_byte unless one is in flight) or an acknowledge (clears rx_valid).
// Output channel (out_valid/out_ready/out_data): exactly one result per
// request, the line and receiver state after that request; rx_done marks
// the tick on which a byte completed, overrun is sticky until reset.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// bit timings; cfg_ready is always high, write only while idle.
// A request's result is written to the output register at the edge that accepts
// it. Throughput is one request per cycle while results are taken, set by the
// single state update between the state registers and the result register.
// in_ready is high while the result register is empty or being
// taken, so a stalled receiver holds its result and blocks only new input.
// Reset puts the transmit line idle high, the receiver waiting for a start
// edge, all flags low and the timing registers at their default values.
`timescale 1ns / 1ps

module timer_based_uart_8n1 #(
    parameter int TIMER_WIDTH = uart_pkg::TIMER_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  uart_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output uart_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uart_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [uart_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DB   = uart_pkg::DATA_BITS;
    // Bit and stop time registers keep the low bits of the 16-bit write, at most TIMER_WIDTH
    localparam int CW   = (TIMER_WIDTH < uart_pkg::CFG_DATA_W) ? TIMER_WIDTH
                                                              : uart_pkg::CFG_DATA_W;
    localparam int DW   = 8;
    localparam int RXCW = CW + 1;
    localparam int RBW  = $clog2(DB + 1);
    localparam int TBW  = $clog2(DB + 4);
    localparam logic [RBW-1:0] RX_BITS_INIT = RBW'(DB);
    localparam logic [TBW-1:0] TX_BITS_INIT = TBW'(DB + 3);
    localparam logic [TBW-1:0] TX_BITS_ONE  = TBW'(1);

    // Timing registers
    logic [CW-1:0] rx_bit_time_reg;
    logic [CW-1:0] rx_half_bit_time_reg;
    logic [CW-1:0] tx_bit_time_reg;
    logic [CW-1:0] tx_stop_time_reg;
    logic [DW-1:0] tx_start_delay_reg;

    // Receiver state
    logic            rx_active_reg,    rx_active_next;
    logic            rx_prev_reg,      rx_prev_next;
    logic [RXCW-1:0] rx_count_reg,     rx_count_next;
    logic [DB-1:0]   rx_shift_reg,     rx_shift_next;
    logic [RBW-1:0]  rx_bits_reg,      rx_bits_next;
    logic [DB-1:0]   rx_hold_reg,      rx_hold_next;
    logic            rx_valid_reg,     rx_valid_next;
    logic            overrun_reg,      overrun_next;

    // Transmitter state; upper frame bits are all ones, so only start and data are kept
    logic [CW-1:0]   tx_count_reg,     tx_count_next;
    logic [DB:0]     tx_shift_reg,     tx_shift_next;
    logic [TBW-1:0]  tx_bits_reg,      tx_bits_next;
    logic            tx_line_reg,      tx_line_next;
    logic            tx_active_reg,    tx_active_next;

    logic                out_valid_reg;
    uart_pkg::out_item_t out_reg, out_next;

    logic            accept;
    logic            rx_done;
    logic [RBW-1:0]  rx_bits_dec;
    logic [TBW-1:0]  tx_bits_dec;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_bit_time_reg      <= CW'(uart_pkg::RST_RX_BIT_TIME);
            rx_half_bit_time_reg <= CW'(uart_pkg::RST_RX_HALF_BIT_TIME);
            tx_bit_time_reg      <= CW'(uart_pkg::RST_TX_BIT_TIME);
            tx_stop_time_reg     <= CW'(uart_pkg::RST_TX_STOP_TIME);
            tx_start_delay_reg   <= DW'(uart_pkg::RST_TX_START_DELAY);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                uart_pkg::REG_RX_BIT_TIME:      rx_bit_time_reg      <= cfg_data[CW-1:0];
                uart_pkg::REG_RX_HALF_BIT_TIME: rx_half_bit_time_reg <= cfg_data[CW-1:0];
                uart_pkg::REG_TX_BIT_TIME:      tx_bit_time_reg      <= cfg_data[CW-1:0];
                uart_pkg::REG_TX_STOP_TIME:     tx_stop_time_reg     <= cfg_data[CW-1:0];
                uart_pkg::REG_TX_START_DELAY:   tx_start_delay_reg   <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rx_active_next = rx_active_reg;
        rx_prev_next   = rx_prev_reg;
        rx_count_next  = rx_count_reg;
        rx_shift_next  = rx_shift_reg;
        rx_bits_next   = rx_bits_reg;
        rx_hold_next   = rx_hold_reg;
        rx_valid_next  = rx_valid_reg;
        overrun_next   = overrun_reg;
        tx_count_next  = tx_count_reg;
        tx_shift_next  = tx_shift_reg;
        tx_bits_next   = tx_bits_reg;
        tx_line_next   = tx_line_reg;
        tx_active_next = tx_active_reg;
        rx_done        = 1'b0;
        rx_bits_dec    = (rx_bits_reg != '0) ? rx_bits_reg - RBW'(1) : '0;
        tx_bits_dec    = tx_bits_reg - TBW'(1);

        unique case (in_data.kind)
            uart_pkg::KIND_TICK:
            begin
                // Receiver: a count of zero or one expires on this tick
                if (rx_active_reg)
                begin
                    if (rx_count_reg[RXCW-1:1] == '0)
                    begin
                        rx_shift_next = {in_data.rx_level, rx_shift_reg[DB-1:1]};
                        rx_count_next = RXCW'(rx_bit_time_reg);
                        rx_bits_next  = rx_bits_dec;
                        if (rx_bits_dec == '0)
                        begin
                            rx_hold_next   = rx_shift_next;
                            overrun_next   = overrun_reg || rx_valid_reg;
                            rx_valid_next  = 1'b1;
                            rx_done        = 1'b1;
                            rx_bits_next   = RX_BITS_INIT;
                            rx_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        rx_count_next = rx_count_reg - RXCW'(1);
                    end
                end
                else if (rx_prev_reg && !in_data.rx_level)
                begin
                    // Start edge: wait one and a half bits to reach mid data bit
                    rx_active_next = 1'b1;
                    rx_count_next  = RXCW'(rx_bit_time_reg) + RXCW'(rx_half_bit_time_reg);
                end
                rx_prev_next = in_data.rx_level;

                // Transmitter
                if (tx_active_reg)
                begin
                    if (tx_count_reg[CW-1:1] == '0)
                    begin
                        tx_count_next = '0;
                        if (tx_bits_reg <= TX_BITS_ONE)
                        begin
                            tx_active_next = 1'b0;
                            tx_bits_next   = '0;
                            tx_line_next   = 1'b1;
                        end
                        else
                        begin
                            tx_line_next  = tx_shift_reg[0];
                            tx_shift_next = {1'b1, tx_shift_reg[DB:1]};
                            tx_bits_next  = tx_bits_dec;
                            tx_count_next = (tx_bits_dec == TX_BITS_ONE) ? tx_stop_time_reg
                                                                         : tx_bit_time_reg;
                        end
                    end
                    else
                    begin
                        tx_count_next = tx_count_reg - CW'(1);
                    end
                end
            end
            uart_pkg::KIND_SEND:
            begin
                // Drop the request while a frame is in flight
                if (!tx_active_reg)
                begin
                    tx_active_next = 1'b1;
                    tx_count_next  = CW'(tx_start_delay_reg);
                    tx_bits_next   = TX_BITS_INIT;
                    tx_shift_next  = {in_data.tx_byte[DB-1:0], 1'b0};
                end
            end
            uart_pkg::KIND_ACK:
            begin
                rx_valid_next = 1'b0;
            end
            default: ;
        endcase

        out_next.tx_level = tx_line_next;
        out_next.tx_busy  = tx_active_next;
        out_next.rx_byte  = 8'(rx_hold_next);
        out_next.rx_valid = rx_valid_next;
        out_next.rx_done  = rx_done;
        out_next.overrun  = overrun_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_active_reg <= 1'b0;
            rx_prev_reg   <= 1'b1;
            rx_count_reg  <= '0;
            rx_shift_reg  <= '0;
            rx_bits_reg   <= RX_BITS_INIT;
            rx_hold_reg   <= '0;
            rx_valid_reg  <= 1'b0;
            overrun_reg   <= 1'b0;
            tx_count_reg  <= '0;
            tx_shift_reg  <= '0;
            tx_bits_reg   <= '0;
            tx_line_reg   <= 1'b1;
            tx_active_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rx_active_reg <= rx_active_next;
                rx_prev_reg   <= rx_prev_next;
                rx_count_reg  <= rx_count_next;
                rx_shift_reg  <= rx_shift_next;
                rx_bits_reg   <= rx_bits_next;
                rx_hold_reg   <= rx_hold_next;
                rx_valid_reg  <= rx_valid_next;
                overrun_reg   <= overrun_next;
                tx_count_reg  <= tx_count_next;
                tx_shift_reg  <= tx_shift_next;
                tx_bits_reg   <= tx_bits_next;
                tx_line_reg   <= tx_line_next;
                tx_active_reg <= tx_active_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    // Overrun never clears once set
    a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overrun_reg |=> overrun_reg)
        else $error("overrun flag cleared");

    // A completed byte is always reported as valid
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rx_done |-> out_reg.rx_valid)
        else $error("rx_done without rx_valid");

    // Idle transmitter holds the line high
    a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_active_reg |-> tx_line_reg)
        else $error("tx line low while idle");

    // Acknowledge clears the valid flag
    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.kind == uart_pkg::KIND_ACK |=> !rx_valid_reg)
        else $error("acknowledge did not clear rx_valid");

endmodule
